// ===== hw/rtl/cfp_pkg.sv =====
// Shared types and constants for the serial-to-CAN frame parser.
// No dependencies; the parser modules and the testbench import this package.
`timescale 1ns / 1ps

package cfp_pkg;

  localparam int unsigned PayloadBytes = 8;
  localparam int unsigned HeaderBytes  = 7;
  localparam int unsigned PldIdxW      = (PayloadBytes > 1) ? $clog2(PayloadBytes) : 1;

  localparam logic [3:0] PosExtFlag = 4'd4;
  localparam logic [3:0] PosRtrFlag = 4'd5;
  localparam logic [3:0] PosLength  = 4'd6;
  localparam logic [3:0] PosData    = 4'(HeaderBytes);
  localparam logic [3:0] PosClose   = 4'(HeaderBytes + PayloadBytes);

  localparam logic [1:0] CfgStartMarker = 2'd0;
  localparam logic [1:0] CfgEndMarker   = 2'd1;
  localparam logic [1:0] CfgGapTimeout  = 2'd2;

  localparam logic [7:0] StartMarkerRst = 8'd253;
  localparam logic [7:0] EndMarkerRst   = 8'd250;
  localparam logic [7:0] GapTimeoutRst  = 8'd50;
  localparam logic [7:0] GapMax         = 8'hFF;

  localparam logic FuncByte = 1'b0;
  localparam logic FuncTick = 1'b1;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] end_marker;
    logic [7:0] gap_timeout_ms;
  } cfp_cfg_t;

endpackage

// ===== hw/rtl/cfp_if.sv =====
// Handshake channel interfaces of the frame parser: input items, result items
// and configuration writes. Depends on nothing.
`timescale 1ns / 1ps

interface cfp_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink (input valid, input func, input rx_byte, output ready);
endinterface

interface cfp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] msg_id;
  logic [7:0]  extended_flag;
  logic [7:0]  remote_flag;
  logic [7:0]  data_length;
  logic [63:0] payload;

  modport source (output valid, output msg_id, output extended_flag, output remote_flag,
                  output data_length, output payload, input ready);
  modport sink (input valid, input msg_id, input extended_flag, input remote_flag,
                input data_length, input payload, output ready);
endinterface

interface cfp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/serial_to_can_frame_parser.sv =====
// Serial-to-CAN frame parser top level: configuration registers and datapath.
// Depends on cfp_pkg, the channel interfaces, cfp_cfg and cfp_core.
//
// Usage:
// The in_i channel carries one item per handshake: a received serial byte
// (func = 0) or a one millisecond tick (func = 1). An idle parser opens a frame
// on the start marker, collects four identifier bytes, two flag bytes, a length
// byte and eight data bytes, and emits one message on out_o when the next byte
// equals the end marker. A byte that arrives after more than the gap timeout of
// ticks aborts the open frame and is then checked as a new start.
// The cfg_i channel writes the start marker, end marker and timeout by index;
// it is always ready and should only be written while the parser is idle.
// An item is registered on acceptance and processed from the input register, so a
// message is registered in the result register before it appears on out_o.
// One item is accepted every cycle while out_o does not stall; the rate is set
// by the combinational state update between the input and result registers.
// When out_o stalls, one further item can be absorbed by the input register,
// after which in_i.ready drops until the result is taken.
// Reset clears the frame state and restores the register defaults 253, 250, 50.
`timescale 1ns / 1ps

module serial_to_can_frame_parser import cfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  cfp_in_if.sink    in_i,
  cfp_out_if.source out_o,
  cfp_cfg_if.sink   cfg_i
);

  cfp_cfg_t cfg;

  cfp_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  cfp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

// ===== hw/rtl/cfp_cfg.sv =====
// Configuration registers of the frame parser: start marker, end marker and
// inter-byte timeout. Depends on cfp_pkg and cfp_cfg_if.
`timescale 1ns / 1ps

module cfp_cfg import cfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  cfp_cfg_if.sink     cfg_i,
  output cfp_cfg_t    cfg_o
);

  cfp_cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker   <= StartMarkerRst;
      cfg_q.end_marker     <= EndMarkerRst;
      cfg_q.gap_timeout_ms <= GapTimeoutRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgStartMarker: cfg_q.start_marker   <= cfg_i.data;
        CfgEndMarker:   cfg_q.end_marker     <= cfg_i.data;
        CfgGapTimeout:  cfg_q.gap_timeout_ms <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/cfp_core.sv =====
// Frame parser datapath: input register, frame state update and result register.
// Depends on cfp_pkg, cfp_in_if and cfp_out_if.
`timescale 1ns / 1ps

module cfp_core import cfp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfp_cfg_t cfg_i,
  cfp_in_if.sink   in_i,
  cfp_out_if.source out_o
);

  logic       s1_valid_q;
  logic       s1_func_q;
  logic [7:0] s1_byte_q;

  logic       in_frame_q, in_frame_d;
  logic [3:0] pos_q, pos_d;
  logic [7:0] gap_q, gap_d;
  logic [31:0] id_q;
  logic [7:0]  ext_q;
  logic [7:0]  rtr_q;
  logic [7:0]  len_q;
  logic [7:0]  pld_q [PayloadBytes];

  logic [31:0] res_id_q;
  logic [7:0]  res_ext_q;
  logic [7:0]  res_rtr_q;
  logic [7:0]  res_len_q;
  logic [63:0] res_pld_q;
  logic        res_valid_q;

  logic        advance;
  logic        step;
  logic        is_byte;
  logic        timed_out;
  logic        live;
  logic        store_en;
  logic        emit;
  logic [63:0] pld_packed;
  logic [3:0]  data_off;

  assign advance    = !res_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || advance;
  assign step       = s1_valid_q && advance;

  assign is_byte   = (s1_func_q == FuncByte);
  assign timed_out = in_frame_q && (gap_q > cfg_i.gap_timeout_ms);
  assign live      = in_frame_q && !timed_out;
  assign store_en  = step && is_byte && live && (pos_q != PosClose);
  assign emit      = is_byte && live && (pos_q == PosClose) && (s1_byte_q == cfg_i.end_marker);
  assign data_off  = pos_q - PosData;

  always_comb begin
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    gap_d      = gap_q;
    if (!is_byte) begin
      if (in_frame_q && gap_q != GapMax) begin
        gap_d = gap_q + 8'd1;
      end
    end else if (live) begin
      gap_d = '0;
      if (pos_q == PosClose) begin
        in_frame_d = 1'b0;
      end else begin
        pos_d = pos_q + 4'd1;
      end
    end else if (s1_byte_q == cfg_i.start_marker) begin
      in_frame_d = 1'b1;
      gap_d      = '0;
      pos_d      = '0;
    end else begin
      in_frame_d = 1'b0;
    end
  end

  always_comb begin
    pld_packed = '0;
    for (int unsigned i = 0; i < PayloadBytes; i++) begin
      pld_packed[8*i +: 8] = pld_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_func_q <= in_i.func;
      s1_byte_q <= in_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      pos_q       <= '0;
      gap_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (step) begin
        in_frame_q <= in_frame_d;
        pos_q      <= pos_d;
        gap_q      <= gap_d;
      end
      if (advance) begin
        res_valid_q <= s1_valid_q && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      if (pos_q >= PosData) begin
        pld_q[data_off[PldIdxW-1:0]] <= s1_byte_q;
      end else if (pos_q == PosLength) begin
        len_q <= s1_byte_q;
      end else if (pos_q == PosRtrFlag) begin
        rtr_q <= s1_byte_q;
      end else if (pos_q == PosExtFlag) begin
        ext_q <= s1_byte_q;
      end else begin
        id_q[8*pos_q[1:0] +: 8] <= s1_byte_q;
      end
    end
    if (step && emit) begin
      res_id_q  <= id_q;
      res_ext_q <= ext_q;
      res_rtr_q <= rtr_q;
      res_len_q <= len_q;
      res_pld_q <= pld_packed;
    end
  end

  assign out_o.valid         = res_valid_q;
  assign out_o.msg_id        = res_id_q;
  assign out_o.extended_flag = res_ext_q;
  assign out_o.remote_flag   = res_rtr_q;
  assign out_o.data_length   = res_len_q;
  assign out_o.payload       = res_pld_q;

endmodule

// ===== dv/tb_serial_to_can_frame_parser.sv =====
// Self-checking testbench for the serial-to-CAN frame parser: random serial frames,
// ticks and register settings, with every message checked against a built-in predictor.
// Depends on cfp_pkg, the channel interfaces in cfp_if.sv and serial_to_can_frame_parser.
`timescale 1ns / 1ps

module tb_serial_to_can_frame_parser import cfp_pkg::*; ();

  localparam int          MaxReports  = 10;
  localparam int          HoldCycles  = 150;
  localparam int          DrainCycles = 4000;
  localparam int          SettleCycles = 8;
  localparam longint      TimeoutNs   = 20_000_000;
  localparam logic [1:0]  CfgUnused   = 2'd3;

  typedef struct packed {
    logic [31:0] msg_id;
    logic [7:0]  ext;
    logic [7:0]  rtr;
    logic [7:0]  len;
    logic [63:0] payload;
  } can_msg_t;

  class can_msg_scoreboard;
    cfp_cfg_t    cfg;
    logic        in_frame;
    logic [3:0]  frame_pos;
    logic [7:0]  gap_ms;
    logic [31:0] id_acc;
    logic [7:0]  ext_acc;
    logic [7:0]  rtr_acc;
    logic [7:0]  len_acc;
    logic [63:0] data_acc;
    can_msg_t    pending[$];
    int          fail_count;
    int          msgs_checked;

    function new();
      cfg = '{start_marker: StartMarkerRst, end_marker: EndMarkerRst,
              gap_timeout_ms: GapTimeoutRst};
      in_frame  = 1'b0;
      frame_pos = '0;
      gap_ms    = '0;
      id_acc    = '0;
      ext_acc   = '0;
      rtr_acc   = '0;
      len_acc   = '0;
      data_acc  = '0;
      fail_count   = 0;
      msgs_checked = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        CfgStartMarker: cfg.start_marker = val;
        CfgEndMarker:   cfg.end_marker = val;
        CfgGapTimeout:  cfg.gap_timeout_ms = val;
        default: ;
      endcase
    endfunction

    function void take_item(logic func, logic [7:0] rx);
      int slot;
      if (func == FuncTick) begin
        if (in_frame && gap_ms != GapMax) gap_ms++;
        return;
      end
      if (in_frame && gap_ms > cfg.gap_timeout_ms) in_frame = 1'b0;
      if (in_frame) begin
        gap_ms = '0;
        if (frame_pos >= PosClose) begin
          in_frame = 1'b0;
          if (rx == cfg.end_marker) begin
            pending.push_back('{msg_id: id_acc, ext: ext_acc, rtr: rtr_acc, len: len_acc,
                                payload: data_acc});
          end
        end else begin
          if (frame_pos >= PosData) begin
            slot = int'(frame_pos) - int'(PosData);
            data_acc[8*slot +: 8] = rx;
          end else if (frame_pos == PosLength) begin
            len_acc = rx;
          end else if (frame_pos == PosRtrFlag) begin
            rtr_acc = rx;
          end else if (frame_pos == PosExtFlag) begin
            ext_acc = rx;
          end else begin
            id_acc = id_acc | (32'(rx) << (8 * int'(frame_pos)));
          end
          frame_pos++;
        end
      end else if (rx == cfg.start_marker) begin
        in_frame  = 1'b1;
        gap_ms    = '0;
        frame_pos = '0;
        id_acc    = '0;
      end
    endfunction

    function void check_msg(can_msg_t got);
      can_msg_t exp;
      msgs_checked++;
      if (pending.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports) begin
          $display("[%0t] unexpected CAN message: id %h ext %h rtr %h len %h data %h",
                   $time, got.msg_id, got.ext, got.rtr, got.len, got.payload);
        end
        return;
      end
      exp = pending.pop_front();
      if (got.msg_id !== exp.msg_id || got.ext !== exp.ext || got.rtr !== exp.rtr ||
          got.len !== exp.len || got.payload !== exp.payload) begin
        fail_count++;
        if (fail_count <= MaxReports) begin
          $display("[%0t] CAN message mismatch (expected/actual):", $time);
          $display("  id %h/%h ext %h/%h rtr %h/%h len %h/%h",
                   exp.msg_id, got.msg_id, exp.ext, got.ext, exp.rtr, got.rtr,
                   exp.len, got.len);
          $display("  data %h/%h", exp.payload, got.payload);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cfp_in_if  in_if();
  cfp_out_if out_if();
  cfp_cfg_if cfg_if();

  serial_to_can_frame_parser u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  can_msg_scoreboard sb = new();
  cfp_cfg_t cur_cfg = '{start_marker: StartMarkerRst, end_marker: EndMarkerRst,
                        gap_timeout_ms: GapTimeoutRst};
  bit in_idle_on   = 1'b1;
  bit out_stall_on = 1'b1;
  bit hold_armed   = 1'b0;
  int hold_count   = 0;
  int items_sent   = 0;
  int frames_sent  = 0;
  int reg_writes   = 0;

  always #5 clk_i = ~clk_i;

  initial begin
    #(TimeoutNs);
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        sb.write_reg(cfg_if.index, cfg_if.data);
        reg_writes++;
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_msg('{msg_id: out_if.msg_id, ext: out_if.extended_flag,
                       rtr: out_if.remote_flag, len: out_if.data_length,
                       payload: out_if.payload});
      end
      if (in_if.valid && in_if.ready) sb.take_item(in_if.func, in_if.rx_byte);
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_armed) hold_count = 0;
      if (hold_armed && hold_count < HoldCycles) begin
        out_if.ready <= 1'b0;
        hold_count++;
      end else if (out_stall_on) begin
        out_if.ready <= ($urandom_range(99) >= 33);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic func, logic [7:0] rx);
    if (in_idle_on) begin
      while ($urandom_range(99) < 33) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_if.valid   <= 1'b1;
    in_if.func    <= func;
    in_if.rx_byte <= rx;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_fixed_frame(logic [31:0] id, logic [7:0] ext, logic [7:0] rtr,
                                  logic [7:0] len, logic [63:0] data, logic [7:0] close);
    send_item(FuncByte, cur_cfg.start_marker);
    for (int i = 0; i < 4; i++) send_item(FuncByte, id[8*i +: 8]);
    send_item(FuncByte, ext);
    send_item(FuncByte, rtr);
    send_item(FuncByte, len);
    for (int i = 0; i < 8; i++) send_item(FuncByte, data[8*i +: 8]);
    send_item(FuncByte, close);
  endtask

  function automatic int short_gap();
    int limit;
    limit = int'(cur_cfg.gap_timeout_ms);
    if ($urandom_range(99) < 75 || limit == 0) return 0;
    return $urandom_range(1, (limit < 2) ? limit : 2);
  endfunction

  task automatic send_noise();
    logic [7:0] rx;
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(1)) begin
        send_item(FuncTick, 8'($urandom));
      end else begin
        rx = 8'($urandom);
        if (rx == cur_cfg.start_marker) rx = rx ^ 8'h01;
        send_item(FuncByte, rx);
      end
    end
  endtask

  task automatic send_frame(bit force_long);
    int long_at;
    int trunc_at;
    int n_ticks;
    int r;
    logic [7:0] rx;
    long_at  = -1;
    trunc_at = 17;
    if (force_long || $urandom_range(99) < ((cur_cfg.gap_timeout_ms <= 8) ? 12 : 3)) begin
      long_at = $urandom_range(1, 16);
    end
    if ($urandom_range(99) < 8) trunc_at = $urandom_range(1, 15);
    if ($urandom_range(99) < 10) send_noise();
    send_item(FuncByte, cur_cfg.start_marker);
    for (int k = 1; k < trunc_at; k++) begin
      n_ticks = (k == long_at) ? int'(cur_cfg.gap_timeout_ms) + $urandom_range(0, 1)
                               : short_gap();
      repeat (n_ticks) send_item(FuncTick, 8'($urandom));
      r = $urandom_range(99);
      if (k == 16) begin
        rx = (r < 80) ? cur_cfg.end_marker :
             (r < 88) ? cur_cfg.start_marker : 8'($urandom);
      end else begin
        rx = (r < 5) ? cur_cfg.start_marker :
             (r < 10) ? cur_cfg.end_marker : 8'($urandom);
      end
      if (k == long_at && n_ticks > int'(cur_cfg.gap_timeout_ms) && $urandom_range(1)) begin
        rx = cur_cfg.start_marker;
      end
      send_item(FuncByte, rx);
    end
    frames_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  task automatic apply_settings(cfp_cfg_t c, bit poke_unused);
    write_reg(CfgStartMarker, c.start_marker);
    if (poke_unused) write_reg(CfgUnused, 8'($urandom));
    write_reg(CfgEndMarker, c.end_marker);
    write_reg(CfgGapTimeout, c.gap_timeout_ms);
    cfg_if.valid <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic drain_msgs();
    int waited;
    waited = 0;
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0 && waited < DrainCycles) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(cfp_cfg_t c, bit reconfigure, bit poke_unused, bit idle_on,
                           bit force_long, int quota);
    int first;
    drain_msgs();
    if (reconfigure) apply_settings(c, poke_unused);
    in_idle_on   = idle_on;
    out_stall_on = idle_on;
    if (force_long) send_frame(1'b1);
    first = items_sent;
    while (items_sent - first < quota) send_frame(1'b0);
  endtask

  initial begin
    in_if.valid   <= 1'b0;
    in_if.func    <= FuncByte;
    in_if.rx_byte <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= CfgStartMarker;
    cfg_if.data   <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(FuncByte, 8'h00);
    send_item(FuncTick, 8'hFF);
    send_fixed_frame(32'hFFFF_FFFF, 8'h00, 8'hFF, 8'hFF, 64'hAA55_FE01_7F80_FF00,
                     cur_cfg.end_marker);

    run_phase(cur_cfg, 1'b0, 1'b0, 1'b1, 1'b1, 130);
    run_phase('{start_marker: 8'h00, end_marker: 8'hFF, gap_timeout_ms: 8'd0},
              1'b1, 1'b0, 1'b1, 1'b0, 120);

    // Hold the result side off while frames keep coming, so the input side backs up.
    hold_armed = 1'b1;
    repeat (3) send_frame(1'b0);
    in_if.valid <= 1'b0;
    wait (hold_count == HoldCycles);
    hold_armed = 1'b0;

    run_phase('{start_marker: 8'hFF, end_marker: 8'h00, gap_timeout_ms: 8'd255},
              1'b1, 1'b0, 1'b1, 1'b1, 150);
    run_phase('{start_marker: 8'h5A, end_marker: 8'h5A, gap_timeout_ms: 8'd1},
              1'b1, 1'b1, 1'b1, 1'b0, 150);
    run_phase('{start_marker: 8'($urandom), end_marker: 8'($urandom),
                gap_timeout_ms: 8'd254}, 1'b1, 1'b0, 1'b0, 1'b1, 150);
    run_phase('{start_marker: 8'($urandom), end_marker: 8'($urandom),
                gap_timeout_ms: 8'd3}, 1'b1, 1'b0, 1'b1, 1'b0, 150);

    drain_msgs();
    if (sb.pending.size() != 0) begin
      $display("%0d expected CAN messages never arrived", sb.pending.size());
      sb.fail_count += sb.pending.size();
    end
    $display("Drove %0d items in %0d frames across six register settings (%0d writes).",
             items_sent, frames_sent, reg_writes);
    $display("Checked %0d CAN messages, %0d mismatches.", sb.msgs_checked, sb.fail_count);
    if (sb.fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/cfp_pkg.sv
hw/rtl/cfp_if.sv
hw/rtl/cfp_cfg.sv
hw/rtl/cfp_core.sv
hw/rtl/serial_to_can_frame_parser.sv
dv/tb_serial_to_can_frame_parser.sv
